@@ rtl/gwm_pkg.sv @@
// Shared types, codes and helpers of the glob wildcard matcher.
// Used by gwm_cell and glob_wildcard_matcher_top; depends on nothing else.
package gwm_pkg;

    // Default number of pattern symbols held by the cell chain.
    localparam int PATTERN_LEN_DEF = 32;

    // Pattern bytes with a special meaning.
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_QUEST  = 8'h3F;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_TEXT   = 2'd2,
        FUNC_END    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        KIND_LIT = 2'd0,
        KIND_ONE = 2'd1,
        KIND_RUN = 2'd2
    } kind_t;

    // Broadcast from the top level to every cell in the chain.
    typedef struct packed {
        logic       step;      // consume one text byte
        logic       rearm;     // return the automaton to the start position
        logic       wr;        // append a symbol at the current pattern count
        kind_t      kind;      // kind of the appended symbol
        logic [7:0] sym_byte;  // case-folded literal of the appended symbol
        logic [7:0] text_byte; // case-folded text byte
    } cell_ctrl_t;

    // ASCII upper case letters fold to lower case; all else is unchanged.
    function automatic logic [7:0] fold_case(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h5A)
        begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

@@ rtl/gwm_cell.sv @@
// One cell of the matcher chain: one pattern symbol and its active-position bit.
// Depends on gwm_pkg.
module gwm_cell #(
    parameter int IDX   = 0,
    parameter int PTR_W = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  gwm_pkg::cell_ctrl_t ctrl,
    input  logic [PTR_W-1:0]    count,
    input  logic                step_in,
    input  logic                carry_in,
    output logic                closed,
    output logic                carry_out,
    output logic                step_out
);
    import gwm_pkg::*;

    kind_t      kind_reg;
    logic [7:0] sym_reg;
    logic       act_reg;
    logic       act_next;
    logic       valid;
    logic       is_run;
    logic       advance;

    // The cell holds a symbol only while its index lies below the pattern count.
    assign valid  = count > PTR_W'(IDX);
    assign closed = act_reg | carry_in;

    always_comb
    begin
        is_run  = 1'b0;
        advance = 1'b0;
        case (kind_reg)
            KIND_RUN: is_run  = 1'b1;
            KIND_ONE: advance = 1'b1;
            KIND_LIT: advance = (sym_reg == ctrl.text_byte);
            default:  advance = 1'b0;
        endcase
    end

    assign carry_out = closed & valid & is_run;
    assign step_out  = closed & valid & advance;

    always_comb
    begin
        act_next = act_reg;
        if (ctrl.rearm)
        begin
            act_next = (IDX == 0);
        end
        else if (ctrl.step)
        begin
            // A run symbol keeps its own position alive across the byte.
            act_next = carry_out | step_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= (IDX == 0);
        end
        else
        begin
            act_reg <= act_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr && count == PTR_W'(IDX))
        begin
            kind_reg <= ctrl.kind;
            sym_reg  <= ctrl.sym_byte;
        end
    end

endmodule

@@ rtl/glob_wildcard_matcher_top.sv @@
// Glob wildcard matcher: top level with word decode, pattern bookkeeping and result register.
// Depends on gwm_pkg and gwm_cell.
//
// The block matches a stream of text bytes against a stored glob pattern.
// Each input word carries a function code and a byte: clear the pattern,
// append a pattern byte, present a text byte, or end the text. '*' matches
// any run of bytes, '?' exactly one byte, and a backslash makes the next
// pattern byte literal. Letters compare with case folded.
// Only an end-of-text word gives a result word: matched, and whether any
// pattern bytes were dropped for lack of room since the last clear.
// Input words may arrive back to back while in_ready is high. The result
// word is registered in the output register, or parked behind it while
// the output is stalled. The clock rate is limited by the cell chain,
// whose run-closure ripples combinationally through all PATTERN_LEN cells.
// A second result register sits behind the output, so one result may wait
// on a stalled receiver without holding off input. Input ready comes from
// a register and drops only once both hold a result, that is after two
// end-of-text words meet a stalled receiver.
// Reset empties the pattern, clears the escape and overflow state and
// arms the automaton at its start position; the symbol store itself is not
// cleared, as only appended entries are ever read.
module glob_wildcard_matcher_top #(
    parameter int PATTERN_LEN = gwm_pkg::PATTERN_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] func,
    input  logic [7:0] byte_value,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       matched,
    output logic       pattern_overflow
);
    import gwm_pkg::*;

    localparam int PTR_W = $clog2(PATTERN_LEN + 1);

    logic [PTR_W-1:0] count_reg, count_next;
    logic             esc_reg, esc_next;
    logic             ovf_reg, ovf_next;
    logic             act_last_reg, act_last_next;
    logic             out_valid_reg, out_valid_next;
    logic             matched_reg, matched_next;
    logic             out_ovf_reg, out_ovf_next;
    logic             skid_valid_reg, skid_valid_next;
    logic             skid_matched_reg, skid_matched_next;
    logic             skid_ovf_reg, skid_ovf_next;

    logic             in_fire;
    func_t            func_code;
    cell_ctrl_t       ctrl;
    logic             append;
    kind_t            app_kind;
    logic [7:0]       app_byte;

    logic [PATTERN_LEN:0] carry_chain;
    logic [PATTERN_LEN:0] step_chain;
    logic [PATTERN_LEN:0] closed_vec;

    assign func_code = func_t'(func);
    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;

    // Pattern byte decode: an escape makes the byte literal, a backslash
    // opens an escape, and the two wildcards become their own kinds.
    always_comb
    begin
        append   = 1'b0;
        app_kind = KIND_LIT;
        app_byte = fold_case(byte_value);
        esc_next = esc_reg;
        if (in_fire && func_code == FUNC_CLEAR)
        begin
            esc_next = 1'b0;
        end
        else if (in_fire && func_code == FUNC_APPEND)
        begin
            if (esc_reg)
            begin
                esc_next = 1'b0;
                append   = 1'b1;
            end
            else if (byte_value == CHAR_BSLASH)
            begin
                esc_next = 1'b1;
            end
            else if (byte_value == CHAR_STAR)
            begin
                append   = 1'b1;
                app_kind = KIND_RUN;
            end
            else if (byte_value == CHAR_QUEST)
            begin
                append   = 1'b1;
                app_kind = KIND_ONE;
            end
            else
            begin
                append = 1'b1;
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        ctrl.wr    = 1'b0;
        if (in_fire && func_code == FUNC_CLEAR)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
        else if (append)
        begin
            if (count_reg < PTR_W'(PATTERN_LEN))
            begin
                ctrl.wr    = 1'b1;
                count_next = count_reg + 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        ctrl.step      = in_fire && func_code == FUNC_TEXT;
        ctrl.rearm     = in_fire && (func_code == FUNC_CLEAR || func_code == FUNC_END);
        ctrl.kind      = app_kind;
        ctrl.sym_byte  = app_byte;
        ctrl.text_byte = fold_case(byte_value);
    end

    assign carry_chain[0] = 1'b0;
    assign step_chain[0]  = 1'b0;

    for (genvar g = 0; g < PATTERN_LEN; g++)
    begin : g_cell
        gwm_cell #(
            .IDX   (g),
            .PTR_W (PTR_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .count     (count_reg),
            .step_in   (step_chain[g]),
            .carry_in  (carry_chain[g]),
            .closed    (closed_vec[g]),
            .carry_out (carry_chain[g+1]),
            .step_out  (step_chain[g+1])
        );
    end

    // The final position has no symbol of its own.
    assign closed_vec[PATTERN_LEN] = act_last_reg | carry_chain[PATTERN_LEN];

    always_comb
    begin
        act_last_next = act_last_reg;
        if (ctrl.rearm)
        begin
            act_last_next = 1'b0;
        end
        else if (ctrl.step)
        begin
            act_last_next = step_chain[PATTERN_LEN];
        end
    end

    // Result register: the whole pattern matched when the position just past
    // its last symbol is active after run closure. A result that arrives while
    // the output one waits is parked in the second register and moves up as
    // soon as the output is taken.
    always_comb
    begin
        out_valid_next    = out_valid_reg;
        matched_next      = matched_reg;
        out_ovf_next      = out_ovf_reg;
        skid_valid_next   = skid_valid_reg;
        skid_matched_next = skid_matched_reg;
        skid_ovf_next     = skid_ovf_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                matched_next    = skid_matched_reg;
                out_ovf_next    = skid_ovf_reg;
                skid_valid_next = 1'b0;
            end
            else if (in_fire && func_code == FUNC_END)
            begin
                out_valid_next = 1'b1;
                matched_next   = closed_vec[count_reg];
                out_ovf_next   = ovf_reg;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (in_fire && func_code == FUNC_END)
        begin
            skid_valid_next   = 1'b1;
            skid_matched_next = closed_vec[count_reg];
            skid_ovf_next     = ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            esc_reg        <= 1'b0;
            ovf_reg        <= 1'b0;
            act_last_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            esc_reg        <= esc_next;
            ovf_reg        <= ovf_next;
            act_last_reg   <= act_last_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        matched_reg      <= matched_next;
        out_ovf_reg      <= out_ovf_next;
        skid_matched_reg <= skid_matched_next;
        skid_ovf_reg     <= skid_ovf_next;
    end

    assign out_valid        = out_valid_reg;
    assign matched          = matched_reg;
    assign pattern_overflow = out_ovf_reg;

    // The pattern count never runs past the chain length.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= PTR_W'(PATTERN_LEN))
        else $error("pattern count beyond chain length");

    // Bytes are only dropped once every cell holds a symbol.
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> count_reg == PTR_W'(PATTERN_LEN))
        else $error("overflow flagged with room left");

    // An accepted end of text always leaves a valid result word on the output next cycle.
    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && func_code == FUNC_END) |=> out_valid_reg)
        else $error("end of text gave no result");

    // A second result is only ever held behind a waiting one.
    a_ready_hold: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("second result held with the output empty");

    // After a rearm the final position is idle.
    a_rearm_last: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.rearm |=> !act_last_reg)
        else $error("final position active after rearm");

endmodule
